### sv/mrfe_pkg.sv
// Shared types, codes and the CRC-16 byte update for the RTU master frame engine.
// No dependencies; imported by every module of the block but the checker.
package mrfe_pkg;

  // Frame size limit default
  localparam int unsigned MAX_FRAME_DEF = 256;

  // Command codes on the input tuser
  localparam logic [1:0] CMD_TX_BYTE = 2'd0;
  localparam logic [1:0] CMD_RX_BYTE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_FUNC_CODE  = 2'd1;
  localparam logic [1:0] CFG_RESP_LEN   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
  localparam logic [7:0]  FUNC_CODE_RST  = 8'd3;
  localparam logic [8:0]  RESP_LEN_RST   = 9'd7;
  localparam logic [15:0] TIMEOUT_RST    = 16'd2000;

  // Verdict codes
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_ADDR    = 3'd2;
  localparam logic [2:0] ST_FUNC    = 3'd3;
  localparam logic [2:0] ST_CRC     = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;

  // Function codes that return register words
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;

  // CRC constants
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One input word
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       last;
  } item_t;

  // One result word
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        word_valid;
    logic [15:0] data_word;
    logic [2:0]  status;
    logic        out_last;
  } res_t;

  // All results of one item, oldest in slot 0
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     res;
  } res_set_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### sv/mrfe_step.sv
// Frame state and the per-item step: request echo with CRC append, response checks,
// word extraction and tick timeout. Depends on mrfe_pkg.
module mrfe_step #(
  parameter int unsigned MaxFrame = mrfe_pkg::MAX_FRAME_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  mrfe_pkg::item_t   item_i,
  input  logic [7:0]        slave_addr_i,
  input  logic [7:0]        func_code_i,
  input  logic [8:0]        resp_len_i,
  input  logic [15:0]       timeout_i,
  output mrfe_pkg::res_set_t set_o
);
  import mrfe_pkg::*;

  localparam int unsigned PosW = $clog2(MaxFrame + 1);

  // Phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TX   = 2'd1;
  localparam logic [1:0] PH_RX   = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]      phase_q, phase_d;
  logic [15:0]     crc_q, crc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      held_q, held_d;
  logic [15:0]     tick_q, tick_d;

  logic [15:0] crc_tx;
  logic [15:0] crc_rx;
  logic [8:0]  n_len;
  logic [9:0]  p10;
  logic [9:0]  n10;
  logic [15:0] tick_inc;
  res_t        r_zero;

  // Request CRC restarts outside the sending phase
  assign crc_tx = crc_byte((phase_q != PH_TX) ? CRC_SEED : crc_q, item_i.data);
  assign crc_rx = crc_byte(crc_q, item_i.data);

  // Clamp the response length to the frame limit
  assign n_len    = (resp_len_i > 9'(MaxFrame)) ? 9'(MaxFrame) : resp_len_i;
  assign n10      = {1'b0, n_len};
  assign p10      = 10'(pos_q);
  assign tick_inc = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
  assign r_zero   = '0;

  // Step logic
  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    pos_d   = pos_q;
    held_d  = held_q;
    tick_d  = tick_q;
    set_o   = '0;
    set_o.cnt = 2'd1;
    set_o.res[0] = r_zero;
    set_o.res[0].out_last = 1'b1;

    if (item_i.cmd == CMD_TX_BYTE) begin
      set_o.res[0].tx_valid = 1'b1;
      set_o.res[0].tx_byte  = item_i.data;
      if (!item_i.last) begin
        phase_d = PH_TX;
        crc_d   = crc_tx;
      end else begin
        // Append CRC low byte first, then open the receive window
        set_o.cnt = 2'd3;
        set_o.res[0].out_last = 1'b0;
        set_o.res[1].tx_valid = 1'b1;
        set_o.res[1].tx_byte  = crc_tx[7:0];
        set_o.res[2].tx_valid = 1'b1;
        set_o.res[2].tx_byte  = crc_tx[15:8];
        set_o.res[2].out_last = 1'b1;
        phase_d = PH_RX;
        crc_d   = CRC_SEED;
        pos_d   = '0;
        held_d  = '0;
        tick_d  = '0;
      end
    end else if (item_i.cmd == CMD_RX_BYTE && phase_q == PH_RX) begin
      if (p10 == 10'd0 && item_i.data != slave_addr_i) begin
        set_o.res[0].status = ST_ADDR;
        phase_d = PH_DONE;
      end else if (p10 == 10'd1 && item_i.data != func_code_i) begin
        set_o.res[0].status = ST_FUNC;
        phase_d = PH_DONE;
      end else if (p10 > 10'd1 && p10 + 10'd1 == n10) begin
        set_o.res[0].status = (crc_q == {item_i.data, held_q}) ? ST_OK : ST_CRC;
        phase_d = PH_DONE;
      end else begin
        // For read function codes, emit a big-endian register word on each completed data pair
        if ((func_code_i == FC_READ_HOLDING || func_code_i == FC_READ_INPUT) &&
            p10 >= 10'd4 && !p10[0] && p10 + 10'd3 <= n10) begin
          set_o.res[0].word_valid = 1'b1;
          set_o.res[0].data_word  = {held_q, item_i.data};
        end
        if (p10 + 10'd2 < n10) begin
          crc_d = crc_rx;
        end
        held_d = item_i.data;
        if (pos_q < PosW'(MaxFrame)) begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end else if (item_i.cmd == CMD_TICK && phase_q == PH_RX) begin
      tick_d = tick_inc;
      if (tick_inc >= timeout_i) begin
        set_o.res[0].status = ST_TIMEOUT;
        phase_d = PH_DONE;
      end
    end
  end

  // Commit state when an item is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      crc_q   <= CRC_SEED;
      pos_q   <= '0;
      held_q  <= '0;
      tick_q  <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      pos_q   <= pos_d;
      held_q  <= held_d;
      tick_q  <= tick_d;
    end
  end

endmodule

### sv/mrfe_outbuf.sv
// Result register for up to three words of one item.
// Drained one word per cycle while the output is ready. Depends on mrfe_pkg.
module mrfe_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  mrfe_pkg::res_set_t set_i,
  input  logic               pop_i,
  output logic               free_o,
  output logic               valid_o,
  output mrfe_pkg::res_t     head_o
);
  import mrfe_pkg::*;

  logic [1:0]  cnt_q, cnt_d;
  res_t [2:0]  buf_q, buf_d;

  // Take a new set once the last pending word leaves
  assign free_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop_i);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = buf_q[0];

  // Load or shift toward the head
  always_comb begin
    cnt_d = cnt_q;
    buf_d = buf_q;
    if (load_i) begin
      cnt_d = set_i.cnt;
      buf_d = set_i.res;
    end else if (pop_i) begin
      cnt_d    = cnt_q - 2'd1;
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

### sv/modbus_rtu_master_frame_engine_unit.sv
// Top level of the RTU master frame engine: configuration registers, input register,
// step logic and result register. Depends on mrfe_pkg, mrfe_step, mrfe_outbuf.
// A word accepted into the input register is processed once the result register has room.
// Throughput: one input word per cycle while each gives one result and the output is ready;
//   a final request byte gives three results and holds the input until they have drained.
// Reset: asynchronous active low; clears config to defaults, phase to idle, CRC to 0xFFFF.
module modbus_rtu_master_frame_engine_unit #(
  parameter int unsigned MaxFrame = mrfe_pkg::MAX_FRAME_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  input  logic        s_axis_tlast_i,
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] tx_byte, [23:8] data_word, [26:24] status
  output logic [1:0]  m_axis_tuser_o,   // [0] tx_valid, [1] word_valid
  output logic        m_axis_tlast_o,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import mrfe_pkg::*;

  logic [7:0]  slave_addr_q;
  logic [7:0]  func_code_q;
  logic [8:0]  resp_len_q;
  logic [15:0] timeout_q;

  item_t    item_q;
  logic     in_vld_q;
  logic     adv;
  logic     free;
  logic     pop;
  res_set_t set;
  res_t     head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SLAVE_ADDR_RST;
      func_code_q  <= FUNC_CODE_RST;
      resp_len_q   <= RESP_LEN_RST;
      timeout_q    <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLAVE_ADDR: slave_addr_q <= cfg_data_i[7:0];
        CFG_FUNC_CODE:  func_code_q  <= cfg_data_i[7:0];
        CFG_RESP_LEN:   resp_len_q   <= cfg_data_i[8:0];
        CFG_TIMEOUT:    timeout_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the held word into the result register when it has room
  assign adv             = in_vld_q && free;
  assign s_axis_tready_o = !in_vld_q || adv;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.cmd  <= s_axis_tuser_i;
      item_q.data <= s_axis_tdata_i;
      item_q.last <= s_axis_tlast_i;
    end
  end

  mrfe_step #(
    .MaxFrame (MaxFrame)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .item_i       (item_q),
    .slave_addr_i (slave_addr_q),
    .func_code_i  (func_code_q),
    .resp_len_i   (resp_len_q),
    .timeout_i    (timeout_q),
    .set_o        (set)
  );

  mrfe_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .set_i   (set),
    .pop_i   (pop),
    .free_o  (free),
    .valid_o (m_axis_tvalid_o),
    .head_o  (head)
  );

  // Pack the head result onto the stream
  assign m_axis_tdata_o = {5'b0, head.status, head.data_word, head.tx_byte};
  assign m_axis_tuser_o = {head.word_valid, head.tx_valid};
  assign m_axis_tlast_o = head.out_last;

endmodule

### sv/mrfe_checker.sv
// Port-level checks for the RTU master frame engine, bound to the top level.
// Depends on modbus_rtu_master_frame_engine_unit port names only.
module mrfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // Hold a stalled result word
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result word changed while stalled");

  // No result words once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // A verdict word carries no transmit byte and no register word
  a_verdict_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[26:24] != 3'd0 |->
      m_axis_tuser_o == 2'b00 && m_axis_tlast_o)
    else $error("verdict mixed with payload");

  // Status stays within its codes, padding stays zero
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[26:24] <= 3'd5 && m_axis_tdata_o[31:27] == 5'd0)
    else $error("bad status or padding");

endmodule

bind modbus_rtu_master_frame_engine_unit mrfe_checker u_mrfe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

### test/modbus_rtu_master_frame_engine_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the RTU master frame engine: streams request, response and tick
// words, predicts each result word in-bench and compares the result stream field by field.
// Depends on mrfe_pkg and modbus_rtu_master_frame_engine_unit.
module modbus_rtu_master_frame_engine_unit_tb;
  import mrfe_pkg::*;

  localparam int unsigned FRAME_MAX  = 256;
  localparam int unsigned RAND_WORDS = 240;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {LINK_IDLE, LINK_SEND, LINK_RECV, LINK_DONE} link_e;
  typedef enum int {RESP_GOOD, RESP_BAD_ADDR, RESP_BAD_FUNC, RESP_BAD_CRC, RESP_TRUNC,
                    RESP_ABORT} resp_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  // Shadow configuration, starts at the reset values
  logic [7:0]  cfg_addr_q = SLAVE_ADDR_RST;
  logic [7:0]  cfg_func_q = FUNC_CODE_RST;
  logic [8:0]  cfg_len_q  = RESP_LEN_RST;
  logic [15:0] cfg_tmo_q  = TIMEOUT_RST;

  // Shadow frame state
  link_e       link_ph  = LINK_IDLE;
  logic [15:0] link_crc = CRC_SEED;
  int unsigned rx_pos   = 0;
  logic [7:0]  rx_held  = '0;
  logic [15:0] rx_ticks = '0;

  item_t       word_backlog[$];
  res_t        want_results[$];

  int unsigned fails = 0;
  int unsigned n_in_acc = 0;
  int unsigned rand_count = 0;
  bit          counting = 1'b0;
  bit          in_took = 1'b0;
  bit          long_hold = 1'b0;
  int          gap_left = 0;
  int          burst_left = 1;
  int          gap_max = 0;
  int          ready_pct = 100;
  int unsigned stall_phase = 0;

  modbus_rtu_master_frame_engine_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Reflected CRC-16, one bit at a time against the incoming byte
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = c;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  // Work out the result words one accepted word causes
  task automatic predict_frame_results(input item_t it);
    res_t        r;
    int unsigned n;
    int unsigned p;
    logic        done;
    r = '0;
    r.out_last = 1'b1;
    if (it.cmd == CMD_TX_BYTE) begin
      if (link_ph != LINK_SEND) link_crc = CRC_SEED;
      link_crc   = crc16_step(link_crc, it.data);
      r.tx_valid = 1'b1;
      r.tx_byte  = it.data;
      if (!it.last) begin
        link_ph = LINK_SEND;
        want_results.push_back(r);
      end else begin
        r.out_last = 1'b0;
        want_results.push_back(r);
        r.tx_byte = link_crc[7:0];
        want_results.push_back(r);
        r.tx_byte  = link_crc[15:8];
        r.out_last = 1'b1;
        want_results.push_back(r);
        link_ph  = LINK_RECV;
        link_crc = CRC_SEED;
        rx_pos   = 0;
        rx_held  = '0;
        rx_ticks = '0;
      end
    end else if (it.cmd == CMD_RX_BYTE && link_ph == LINK_RECV) begin
      n    = (cfg_len_q > FRAME_MAX) ? FRAME_MAX : cfg_len_q;
      p    = rx_pos;
      done = 1'b0;
      if (p == 0) begin
        if (it.data != cfg_addr_q) begin
          r.status = ST_ADDR;
          done = 1'b1;
        end
      end else if (p == 1) begin
        if (it.data != cfg_func_q) begin
          r.status = ST_FUNC;
          done = 1'b1;
        end
      end else if (n >= 1 && p == n - 1) begin
        r.status = (link_crc == {it.data, rx_held}) ? ST_OK : ST_CRC;
        done = 1'b1;
      end
      if (done) begin
        link_ph = LINK_DONE;
      end else begin
        if ((cfg_func_q == FC_READ_HOLDING || cfg_func_q == FC_READ_INPUT) &&
            p >= 4 && (p % 2) == 0 && p + 3 <= n) begin
          r.word_valid = 1'b1;
          r.data_word  = {rx_held, it.data};
        end
        if (p + 2 < n) link_crc = crc16_step(link_crc, it.data);
        rx_held = it.data;
        if (rx_pos < FRAME_MAX) rx_pos++;
      end
      want_results.push_back(r);
    end else if (it.cmd == CMD_TICK && link_ph == LINK_RECV) begin
      if (rx_ticks != 16'hFFFF) rx_ticks++;
      if (rx_ticks >= cfg_tmo_q) begin
        r.status = ST_TIMEOUT;
        link_ph  = LINK_DONE;
      end
      want_results.push_back(r);
    end else begin
      want_results.push_back(r);
    end
  endtask

  // Sender: bursts with random gaps, hold a word until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_took) begin
      in_took = 1'b0;
      if (gap_left > 0 && !long_hold) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (word_backlog.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= word_backlog[0].data;
        s_tuser  <= word_backlog[0].cmd;
        s_tlast  <= word_backlog[0].last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Predict on every accepted input word
  always @(posedge clk) begin : in_mon
    item_t it;
    if (rst_n && s_tvalid && s_tready) begin
      it.cmd  = s_tuser;
      it.data = s_tdata;
      it.last = s_tlast;
      void'(word_backlog.pop_front());
      predict_frame_results(it);
      in_took = 1'b1;
      n_in_acc++;
    end
  end

  // Receiver: stall on its own pattern, or hold off entirely on request
  always @(negedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else if (long_hold) begin
      m_tready <= 1'b0;
    end else begin
      stall_phase = stall_phase + 1;
      m_tready <= (ready_pct >= 100) ||
                  ((stall_phase % 5) != 0 && $urandom_range(0, 99) < ready_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : out_mon
    res_t w;
    if (rst_n && m_tvalid && m_tready) begin
      if (want_results.size() == 0) begin
        $error("result word with nothing predicted: tdata %h tuser %h", m_tdata, m_tuser);
        fails++;
      end else begin
        w = want_results.pop_front();
        check_field("tx_valid", w.tx_valid, m_tuser[0]);
        check_field("tx_byte", w.tx_byte, m_tdata[7:0]);
        check_field("word_valid", w.word_valid, m_tuser[1]);
        check_field("data_word", w.data_word, m_tdata[23:8]);
        check_field("status", w.status, m_tdata[26:24]);
        check_field("out_last", w.out_last, m_tlast);
        check_field("tdata pad", '0, m_tdata[31:27]);
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    while (n_in_acc < 150 || word_backlog.size() < 8) @(posedge clk);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (60) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("** modbus_rtu_master_frame_engine_unit: FAILED **");
    $finish;
  end

  task automatic queue_word(input logic [1:0] cmd, input logic [7:0] data, input logic last,
                            input bit real_work);
    item_t it;
    it.cmd  = cmd;
    it.data = data;
    it.last = last;
    word_backlog.push_back(it);
    if (counting && real_work) rand_count++;
  endtask

  task automatic queue_request(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      queue_word(CMD_TX_BYTE, 8'($urandom_range(0, 255)), i == len - 1, 1'b1);
    end
  endtask

  // Build a response frame for the current setting, then damage or cut it per kind
  task automatic queue_response(input resp_e kind);
    logic [7:0]  fr [FRAME_MAX];
    logic [15:0] c;
    int unsigned n;
    int unsigned cut;
    int unsigned pos;
    int unsigned ticks_sent;
    n = (cfg_len_q > FRAME_MAX) ? FRAME_MAX : cfg_len_q;
    if (n < 4) n = 4;
    fr[0] = cfg_addr_q;
    fr[1] = cfg_func_q;
    fr[2] = 8'(n - 5);
    for (int unsigned i = 3; i < n - 2; i++) fr[i] = 8'($urandom_range(0, 255));
    c = CRC_SEED;
    for (int unsigned i = 0; i < n - 2; i++) c = crc16_step(c, fr[i]);
    fr[n-2] = c[7:0];
    fr[n-1] = c[15:8];
    cut = n;
    case (kind)
      RESP_BAD_ADDR: begin
        fr[0] ^= 8'(1 << $urandom_range(0, 7));
        cut = $urandom_range(1, n);
      end
      RESP_BAD_FUNC: begin
        fr[1] ^= 8'(1 << $urandom_range(0, 7));
        cut = $urandom_range(2, n);
      end
      RESP_BAD_CRC: begin
        pos = $urandom_range(2, n - 1);
        fr[pos] ^= 8'(1 << $urandom_range(0, 7));
      end
      RESP_TRUNC, RESP_ABORT: cut = $urandom_range(0, n - 1);
      default: ;
    endcase
    ticks_sent = 0;
    for (int unsigned i = 0; i < cut; i++) begin
      // Sprinkle ticks that stay short of the timeout
      if ($urandom_range(0, 5) == 0 && ticks_sent + 1 < cfg_tmo_q) begin
        queue_word(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        ticks_sent++;
      end
      queue_word(CMD_RX_BYTE, fr[i], 1'($urandom_range(0, 1)), 1'b1);
    end
    if (kind == RESP_TRUNC) begin
      if (cfg_tmo_q <= 64) begin
        repeat ((cfg_tmo_q > ticks_sent) ? cfg_tmo_q - ticks_sent : 1)
          queue_word(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        repeat (3) queue_word(CMD_TICK, 8'h00, 1'b0, 1'b1);
      end
    end else if (kind == RESP_ABORT) begin
      queue_request($urandom_range(1, 4));
    end
  endtask

  task automatic queue_noise(input int unsigned count);
    repeat (count) begin
      queue_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  // One request and its response, or a short run of noise
  task automatic queue_transaction();
    resp_e kind;
    if ($urandom_range(0, 99) < 12) begin
      queue_noise($urandom_range(1, 4));
    end else begin
      queue_request($urandom_range(1, 6));
      kind = ($urandom_range(0, 99) < 50) ? RESP_GOOD : resp_e'($urandom_range(1, 5));
      queue_response(kind);
      repeat ($urandom_range(0, 2)) begin
        queue_word(($urandom_range(0, 1) == 0) ? CMD_RX_BYTE : CMD_TICK,
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
      end
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SLAVE_ADDR: cfg_addr_q = val[7:0];
      CFG_FUNC_CODE:  cfg_func_q = val[7:0];
      CFG_RESP_LEN:   cfg_len_q  = val[8:0];
      CFG_TIMEOUT:    cfg_tmo_q  = val;
      default: ;
    endcase
  endtask

  // Write every register and pick new idling for both sides
  task automatic set_config(input logic [7:0] addr, input logic [7:0] func,
                            input logic [8:0] len, input logic [15:0] tmo);
    int unsigned sel;
    cfg_write(CFG_SLAVE_ADDR, {8'h00, addr});
    cfg_write(CFG_FUNC_CODE, {8'h00, func});
    cfg_write(CFG_RESP_LEN, {7'h00, len});
    cfg_write(CFG_TIMEOUT, tmo);
    sel = $urandom_range(0, 2);
    gap_max   = (sel == 0) ? 0 : (sel == 1) ? 3 : 8;
    sel = $urandom_range(0, 2);
    ready_pct = (sel == 0) ? 100 : (sel == 1) ? 70 : 40;
  endtask

  // Wait until every word is sent and every result is back, then let the pipe drain
  task automatic settle();
    while (word_backlog.size() != 0 || want_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [7:0]  r_addr;
    logic [7:0]  r_func;
    logic [8:0]  r_len;
    logic [15:0] r_tmo;
    int unsigned sel;
    repeat (4) @(posedge clk);
    @(negedge clk);
    #1 rst_n = 1'b1;

    // Directed: reset configuration, edge words and the OK, address, function and CRC verdicts
    gap_max   = 2;
    ready_pct = 70;
    queue_word(CMD_UNUSED, 8'hFF, 1'b1, 1'b0);
    queue_word(CMD_RX_BYTE, 8'h01, 1'b0, 1'b0);
    queue_word(CMD_TICK, 8'h00, 1'b0, 1'b0);
    queue_word(CMD_TX_BYTE, 8'h00, 1'b0, 1'b0);
    queue_word(CMD_TX_BYTE, 8'hFF, 1'b1, 1'b0);
    queue_response(RESP_GOOD);
    queue_word(CMD_RX_BYTE, 8'h55, 1'b0, 1'b0);
    queue_word(CMD_TICK, 8'hAA, 1'b1, 1'b0);
    queue_request(1);
    queue_response(RESP_BAD_ADDR);
    queue_request(1);
    queue_response(RESP_BAD_FUNC);
    queue_request(1);
    queue_response(RESP_BAD_CRC);
    settle();

    // Length of four, timeout of one tick
    set_config(8'h00, FC_READ_INPUT, 9'd4, 16'd1);
    repeat (4) queue_transaction();
    queue_request(2);
    queue_response(RESP_TRUNC);
    settle();

    // Random settings and traffic
    counting = 1'b1;
    while (rand_count < RAND_WORDS) begin
      r_addr = 8'($urandom_range(0, 255));
      sel    = $urandom_range(0, 99);
      r_func = (sel < 40) ? FC_READ_HOLDING : (sel < 70) ? FC_READ_INPUT :
               8'($urandom_range(0, 255));
      r_len  = ($urandom_range(0, 99) < 80) ? 9'($urandom_range(4, 12)) :
               9'($urandom_range(0, 3));
      sel    = $urandom_range(0, 99);
      r_tmo  = (sel < 40) ? 16'($urandom_range(1, 8)) :
               (sel < 80) ? 16'($urandom_range(100, 2000)) : 16'd0;
      set_config(r_addr, r_func, r_len, r_tmo);
      repeat ($urandom_range(3, 6)) queue_transaction();
      settle();
    end
    counting = 1'b0;

    // Zero length never reaches a CRC verdict; only a tick ends the frame
    set_config(8'($urandom_range(0, 255)), 8'hFF, 9'd0, 16'd0);
    queue_request(2);
    for (int unsigned i = 0; i < 6; i++) begin
      queue_word(CMD_RX_BYTE, (i == 0) ? cfg_addr_q : (i == 1) ? cfg_func_q :
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    end
    queue_word(CMD_TICK, 8'h00, 1'b0, 1'b0);
    queue_word(CMD_RX_BYTE, 8'h00, 1'b0, 1'b0);
    settle();

    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("** modbus_rtu_master_frame_engine_unit: PASSED **");
    end else begin
      $display("** modbus_rtu_master_frame_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule

### modbus_rtu_master_frame_engine_unit.f
sv/mrfe_pkg.sv
sv/mrfe_step.sv
sv/mrfe_outbuf.sv
sv/modbus_rtu_master_frame_engine_unit.sv
sv/mrfe_checker.sv
test/modbus_rtu_master_frame_engine_unit_tb.sv
